// ----- rtl/tlb_page_table_translator_defines.svh -----
// Assertion macros shared by the address translator RTL.
`ifndef TLB_PAGE_TABLE_TRANSLATOR_DEFINES_SVH
`define TLB_PAGE_TABLE_TRANSLATOR_DEFINES_SVH

`ifndef ASSERT_OFF
`define TPT_ASSERT(lbl, expr) \
   lbl: assert property (@(posedge clock) disable iff (reset) (expr)) \
      else $error("tlb translator check failed");
`define TPT_ASSERT_IMPL(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("tlb translator check failed");
`else
`define TPT_ASSERT(lbl, expr)
`define TPT_ASSERT_IMPL(lbl, ante, cons)
`endif

`endif

// ----- rtl/tpt_pkg.sv -----
// Types and constants of the page table address translator.
`default_nettype none

package tpt_pkg;

   localparam int ADDR_BITS   = 16;
   localparam int OFFSET_BITS = 8;
   localparam int PAGE_BITS   = 8;
   localparam int PAGE_COUNT  = 256;
   localparam int FRAME_BITS  = 8;
   localparam int FREE_BITS   = 9;
   localparam int COUNT_BITS  = 16;

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = 16'hFFFF;

   typedef struct packed {
      logic [ADDR_BITS-1:0] logical_address;
   } tpt_req_type;

   typedef struct packed {
      logic [PAGE_BITS-1:0]   page_number;
      logic [OFFSET_BITS-1:0] page_offset;
      logic [FRAME_BITS-1:0]  frame_number;
      logic [ADDR_BITS-1:0]   physical_address;
      logic                   tlb_hit;
      logic                   page_fault;
      logic [COUNT_BITS-1:0]  hit_total;
      logic [COUNT_BITS-1:0]  fault_total;
   } tpt_rsp_type;

endpackage

`default_nettype wire

// ----- rtl/tpt_stream_if.sv -----
// Valid/ready stream channel carrying one payload word.
`default_nettype none

interface tpt_stream_if #(
   parameter type payload_type = logic
) ();
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ----- rtl/tlb_page_table_translator.sv -----
// Demand-paging address translator: the FIFO TLB and the page table under one sequencer.
`default_nettype none
`include "tlb_page_table_translator_defines.svh"

// Each request carries a logical address; the block returns one response with
// the page, offset, frame, physical address, hit and fault flags and the
// saturating hit and fault totals. The TLB sits in a memory with one write
// port and one read port and is scanned one entry per cycle through one
// comparator, over the valid TLB entries only. A miss reads the page table
// memory once and, on a page fault, assigns the next free frame in order.
// One request is handled at a time; a finished response waits in the output
// register while the next request is taken.
module tlb_page_table_translator
   import tpt_pkg::*;
#(
   parameter int TLB_ENTRIES = 16
) (
   input  logic          clock,
   input  logic          reset,
   tpt_stream_if.sink    req_if,
   tpt_stream_if.source  rsp_if
);

   localparam int PTR_W  = (TLB_ENTRIES > 1) ? $clog2(TLB_ENTRIES) : 1;
   localparam int FILL_W = $clog2(TLB_ENTRIES + 1);
   localparam int ENTRY_W = PAGE_BITS + FRAME_BITS;
   localparam logic [PTR_W-1:0]  LAST_PTR   = PTR_W'(TLB_ENTRIES - 1);
   localparam logic [FILL_W-1:0] FULL_COUNT = FILL_W'(TLB_ENTRIES);

   localparam logic [2:0] ST_IDLE    = 3'd0;
   localparam logic [2:0] ST_SCAN    = 3'd1;
   localparam logic [2:0] ST_PT_READ = 3'd2;
   localparam logic [2:0] ST_PT_EVAL = 3'd3;
   localparam logic [2:0] ST_FINISH  = 3'd4;

   function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
      return (p == LAST_PTR) ? '0 : p + 1'b1;
   endfunction

   function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
      return (v == COUNT_MAX) ? v : v + 1'b1;
   endfunction

   logic [2:0]            state_ff, state_in;
   logic [ADDR_BITS-1:0]  addr_ff, addr_in;
   logic [PTR_W-1:0]      head_ff, head_in;
   logic [PTR_W-1:0]      tail_ff, tail_in;
   logic [FILL_W-1:0]     fill_ff, fill_in;
   logic [PTR_W-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [FILL_W-1:0]     issue_cnt_ff, issue_cnt_in;
   logic                  cmp_vld_ff, cmp_vld_in;
   logic                  hit_ff, hit_in;
   logic                  fault_ff, fault_in;
   logic [FRAME_BITS-1:0] frame_ff, frame_in;
   logic [PAGE_COUNT-1:0] mapped_ff, mapped_in;
   logic [FREE_BITS-1:0]  next_free_ff, next_free_in;
   logic [COUNT_BITS-1:0] hit_cnt_ff, hit_cnt_in;
   logic [COUNT_BITS-1:0] fault_cnt_ff, fault_cnt_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   tpt_rsp_type           rsp_data_ff, rsp_data_in;

   logic [ENTRY_W-1:0]    tlb_mem [TLB_ENTRIES];
   logic [ENTRY_W-1:0]    tlb_rdata_ff;
   logic                  tlb_we;
   logic [FRAME_BITS-1:0] pt_mem [PAGE_COUNT];
   logic [FRAME_BITS-1:0] pt_rdata_ff;
   logic                  pt_we;

   logic [PAGE_BITS-1:0]   page;
   logic [OFFSET_BITS-1:0] offset;
   logic [COUNT_BITS-1:0]  hit_cnt_next;
   logic [COUNT_BITS-1:0]  fault_cnt_next;

   assign page   = addr_ff[ADDR_BITS-1 -: PAGE_BITS];
   assign offset = addr_ff[OFFSET_BITS-1:0];

   assign hit_cnt_next   = hit_ff   ? sat_inc(hit_cnt_ff)   : hit_cnt_ff;
   assign fault_cnt_next = fault_ff ? sat_inc(fault_cnt_ff) : fault_cnt_ff;

   assign req_if.ready   = (state_ff == ST_IDLE);
   assign rsp_if.valid   = rsp_valid_ff;
   assign rsp_if.payload = rsp_data_ff;

   always_comb begin
      state_in     = state_ff;
      addr_in      = addr_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      fill_in      = fill_ff;
      rd_ptr_in    = rd_ptr_ff;
      issue_cnt_in = issue_cnt_ff;
      cmp_vld_in   = 1'b0;
      hit_in       = hit_ff;
      fault_in     = fault_ff;
      frame_in     = frame_ff;
      mapped_in    = mapped_ff;
      next_free_in = next_free_ff;
      hit_cnt_in   = hit_cnt_ff;
      fault_cnt_in = fault_cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_if.ready;
      rsp_data_in  = rsp_data_ff;
      tlb_we       = 1'b0;
      pt_we        = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_if.valid) begin
               addr_in      = req_if.payload.logical_address;
               hit_in       = 1'b0;
               fault_in     = 1'b0;
               rd_ptr_in    = head_ff;
               issue_cnt_in = '0;
               state_in     = ST_SCAN;
            end
         end
         ST_SCAN: begin
            // Reads go out in FIFO order, oldest first, so a later match overrides.
            if (issue_cnt_ff != fill_ff) begin
               cmp_vld_in   = 1'b1;
               rd_ptr_in    = ptr_inc(rd_ptr_ff);
               issue_cnt_in = issue_cnt_ff + 1'b1;
            end
            if (cmp_vld_ff && tlb_rdata_ff[ENTRY_W-1 -: PAGE_BITS] == page) begin
               hit_in   = 1'b1;
               frame_in = tlb_rdata_ff[FRAME_BITS-1:0];
            end
            if (issue_cnt_ff == fill_ff && !cmp_vld_ff) begin
               state_in = hit_ff ? ST_FINISH : ST_PT_READ;
            end
         end
         ST_PT_READ: begin
            state_in = ST_PT_EVAL;
         end
         ST_PT_EVAL: begin
            if (mapped_ff[page]) begin
               frame_in = pt_rdata_ff;
            end else begin
               frame_in        = next_free_ff[FRAME_BITS-1:0];
               pt_we           = 1'b1;
               mapped_in[page] = 1'b1;
               next_free_in    = next_free_ff + 1'b1;
               fault_in        = 1'b1;
            end
            // When the TLB is full the write at the tail overwrites the oldest entry.
            tlb_we  = 1'b1;
            tail_in = ptr_inc(tail_ff);
            if (fill_ff == FULL_COUNT) begin
               head_in = ptr_inc(head_ff);
            end else begin
               fill_in = fill_ff + 1'b1;
            end
            state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_if.ready) begin
               hit_cnt_in   = hit_cnt_next;
               fault_cnt_in = fault_cnt_next;
               rsp_valid_in = 1'b1;
               rsp_data_in.page_number      = page;
               rsp_data_in.page_offset      = offset;
               rsp_data_in.frame_number     = frame_ff;
               rsp_data_in.physical_address = {frame_ff, offset};
               rsp_data_in.tlb_hit          = hit_ff;
               rsp_data_in.page_fault       = fault_ff;
               rsp_data_in.hit_total        = hit_cnt_next;
               rsp_data_in.fault_total      = fault_cnt_next;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         fill_ff      <= '0;
         cmp_vld_ff   <= 1'b0;
         mapped_ff    <= '0;
         next_free_ff <= '0;
         hit_cnt_ff   <= '0;
         fault_cnt_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         fill_ff      <= fill_in;
         cmp_vld_ff   <= cmp_vld_in;
         mapped_ff    <= mapped_in;
         next_free_ff <= next_free_in;
         hit_cnt_ff   <= hit_cnt_in;
         fault_cnt_ff <= fault_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      addr_ff      <= addr_in;
      rd_ptr_ff    <= rd_ptr_in;
      issue_cnt_ff <= issue_cnt_in;
      hit_ff       <= hit_in;
      fault_ff     <= fault_in;
      frame_ff     <= frame_in;
      rsp_data_ff  <= rsp_data_in;
   end

   // TLB store: one write port at the tail, one registered read port for the scan.
   always_ff @(posedge clock) begin
      if (tlb_we) begin
         tlb_mem[tail_ff] <= {page, frame_in};
      end
      tlb_rdata_ff <= tlb_mem[rd_ptr_ff];
   end

   // Page table frames; only entries whose mapped bit is set are ever used.
   always_ff @(posedge clock) begin
      if (pt_we) begin
         pt_mem[page] <= next_free_ff[FRAME_BITS-1:0];
      end
      pt_rdata_ff <= pt_mem[page];
   end

   `TPT_ASSERT(a_fill_bound, fill_ff <= FULL_COUNT)
   `TPT_ASSERT_IMPL(a_head_until_full, fill_ff != FULL_COUNT, head_ff == '0)
   `TPT_ASSERT_IMPL(a_hit_xor_fault, rsp_valid_ff, !(rsp_data_ff.tlb_hit && rsp_data_ff.page_fault))
   `TPT_ASSERT_IMPL(a_hit_counted, rsp_valid_ff && rsp_data_ff.tlb_hit, rsp_data_ff.hit_total != '0)

endmodule

`default_nettype wire
